>>> src/serc_pkg.sv
// ----------------------------------------------------------------------------
// serc_pkg
// shared types, codes and helper functions of the response checker
// ----------------------------------------------------------------------------
package serc_pkg;

	// frame framing constants
	localparam logic [7:0]  SYNC_BYTE   = 8'h55;
	localparam logic [15:0] STATUS_OK   = 16'h9000;
	localparam logic [15:0] CRC_INIT    = 16'h0000;
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam int          MAX_FRAME_D = 4096;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENCRYPT_ENABLE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT      = 3'd4;
	localparam logic [8:0]           POLL_LIMIT_RESET    = 9'd256;

	// queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_BODY,
		PH_CRC_HI,
		PH_CRC_LO
	} phase_t;

	typedef enum logic [2:0] {
		TK_SYNC,
		TK_TIMEOUT,
		TK_DATA,
		TK_STAT_HI,
		TK_STAT_LO,
		TK_CRC_HI,
		TK_CRC_LO
	} tok_kind_t;

	typedef enum logic [2:0] {
		V_OK      = 3'd0,
		V_CRC     = 3'd1,
		V_LENGTH  = 3'd2,
		V_STATUS  = 3'd3,
		V_TIMEOUT = 3'd4
	} verdict_t;

	typedef enum logic {
		K_DATA    = 1'b0,
		K_VERDICT = 1'b1
	} res_kind_t;

	// classified byte handed from front to back
	typedef struct packed {
		tok_kind_t   kind;
		logic [7:0]  rx;
		logic [3:0]  key_idx;
		logic        len_ok;
	} tok_t;

	typedef struct packed {
		logic [11:0]  expected_length;
		logic         encrypt_enable;
		logic [127:0] key;
		logic [8:0]   poll_limit;
	} cfg_t;

	typedef struct packed {
		res_kind_t   kind;
		logic [7:0]  data_byte;
		verdict_t    verdict;
		logic [7:0]  status_hi;
		logic [7:0]  status_lo;
		logic        last;
	} res_t;

	// bytewise crc-16, msb first
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] key_byte(input logic [127:0] key, input logic [3:0] idx);
		return key[{idx, 3'b000} +: 8];
	endfunction

endpackage

>>> src/serc_in_if.sv
// ----------------------------------------------------------------------------
// serc_in_if
// received byte channel
// ----------------------------------------------------------------------------
interface serc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

>>> src/serc_out_if.sv
// ----------------------------------------------------------------------------
// serc_out_if
// result channel: data bytes and frame verdicts
// ----------------------------------------------------------------------------
interface serc_out_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;
	logic [2:0] verdict;
	logic [7:0] status_hi;
	logic [7:0] status_lo;
	logic       last;

	modport source (output valid, output kind, output data_byte, output verdict,
		output status_hi, output status_lo, output last, input ready);
	modport sink (input valid, input kind, input data_byte, input verdict,
		input status_hi, input status_lo, input last, output ready);
endinterface

>>> src/serc_cfg_if.sv
// ----------------------------------------------------------------------------
// serc_cfg_if
// configuration write channel
// ----------------------------------------------------------------------------
interface serc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [serc_pkg::CFG_IDX_W-1:0]   index;
	logic [serc_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/secure_element_response_checker_top.sv
// ----------------------------------------------------------------------------
// secure_element_response_checker_top
// framed secure element response checker with crc-16 and key descrambling
// ----------------------------------------------------------------------------
// One received byte is taken per word on rx, one per clock sustained. The
// parser hunts for the 0x55 sync byte (a timeout verdict after poll_limit
// other bytes), reads the 16-bit length, then expected_length data bytes
// (capped at MAX_FRAME - 6), the two status bytes and the crc (poly 0x1021,
// init 0, high byte first). Data words leave on rsp as they arrive,
// descrambled with key byte (position mod 16) when encrypt_enable is set,
// and only while the length field equals the capped length plus two; each
// frame ends in one verdict word. The rate is one byte a cycle, set by the
// bytewise crc and xor stage in the checker; a two-word queue parts parser
// from checker and an output register holds a result while rsp is stalled,
// so rx backs up only once both are full. Configuration is to be written
// through cfg while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module secure_element_response_checker_top #(
	parameter int MAX_FRAME = serc_pkg::MAX_FRAME_D
) (
	input  logic        clk,
	input  logic        arst_n,
	serc_in_if.sink     rx,
	serc_out_if.source  rsp,
	serc_cfg_if.sink    cfg
);

	// configuration registers
	serc_pkg::cfg_t cfg_q;

	// parser to queue
	logic           push;
	serc_pkg::tok_t push_tok;
	logic           q_full;

	// queue to checker
	logic           pop;
	logic           q_not_empty;
	serc_pkg::tok_t head;

	// registers are always writable, unknown indexes are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_length <= '0;
			cfg_q.encrypt_enable  <= 1'b0;
			cfg_q.key             <= '0;
			cfg_q.poll_limit      <= serc_pkg::POLL_LIMIT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				serc_pkg::CFG_EXPECTED_LENGTH: cfg_q.expected_length <= cfg.data[11:0];
				serc_pkg::CFG_ENCRYPT_ENABLE:  cfg_q.encrypt_enable  <= cfg.data[0];
				serc_pkg::CFG_KEY_LOW:         cfg_q.key[63:0]       <= cfg.data;
				serc_pkg::CFG_KEY_HIGH:        cfg_q.key[127:64]     <= cfg.data;
				serc_pkg::CFG_POLL_LIMIT:      cfg_q.poll_limit      <= cfg.data[8:0];
				default: ;
			endcase
		end
	end

	// front: sync hunt, length and body position, byte classification
	serc_front #(
		.MAX_FRAME (MAX_FRAME)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.cfg    (cfg_q),
		.q_full (q_full),
		.push   (push),
		.tok    (push_tok)
	);

	// two-word queue, lets parser and checker stall apart
	serc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_tok  (push_tok),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (head)
	);

	// back: crc, descrambling, verdict, result register
	serc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.rsp         (rsp)
	);

endmodule

>>> src/serc_front.sv
// ----------------------------------------------------------------------------
// serc_front
// frame parser: tracks sync, length and body position, classifies each byte
// ----------------------------------------------------------------------------
module serc_front #(
	parameter int MAX_FRAME = serc_pkg::MAX_FRAME_D
) (
	input  logic               clk,
	input  logic               arst_n,
	serc_in_if.sink            rx,
	input  serc_pkg::cfg_t     cfg,
	input  logic               q_full,
	output logic               push,
	output serc_pkg::tok_t     tok
);

	localparam int IDX_W = $clog2(MAX_FRAME + 1);
	localparam int LW    = (IDX_W > 16) ? IDX_W : 16;
	localparam logic [LW-1:0] CAP = LW'(MAX_FRAME - 6);

	serc_pkg::phase_t phase_q, phase_d;
	logic [8:0]       poll_count_q, poll_count_d;
	logic [IDX_W-1:0] byte_index_q, byte_index_d;
	logic [15:0]      length_field_q, length_field_d;

	logic             accept;
	logic             tok_valid;
	logic [LW-1:0]    exp_len, eff_len, idx_ext;
	logic             len_ok, idx_lt, idx_eq, is_sync, timeout;
	logic [8:0]       poll_inc;

	assign rx.ready = !q_full;
	assign accept   = rx.valid && !q_full;
	assign push     = accept && tok_valid;

	assign exp_len  = LW'(cfg.expected_length);
	assign eff_len  = (exp_len > CAP) ? CAP : exp_len;
	assign idx_ext  = LW'(byte_index_q);
	assign len_ok   = LW'(length_field_q) == (eff_len + LW'(2));
	assign idx_lt   = idx_ext < eff_len;
	assign idx_eq   = idx_ext == eff_len;
	assign is_sync  = rx.rx_byte == serc_pkg::SYNC_BYTE;
	assign poll_inc = poll_count_q + 9'd1;
	// a limit of zero times out on the first byte, same as one
	assign timeout  = (poll_inc >= cfg.poll_limit) || (poll_inc == 9'd0);

	// next state
	always_comb begin
		phase_d        = phase_q;
		poll_count_d   = poll_count_q;
		byte_index_d   = byte_index_q;
		length_field_d = length_field_q;
		unique case (phase_q)
			serc_pkg::PH_HUNT: begin
				if (is_sync) begin
					phase_d        = serc_pkg::PH_LEN_HI;
					poll_count_d   = '0;
					byte_index_d   = '0;
					length_field_d = '0;
				end else if (timeout) begin
					poll_count_d = '0;
				end else begin
					poll_count_d = poll_inc;
				end
			end
			serc_pkg::PH_LEN_HI: begin
				length_field_d = {rx.rx_byte, 8'h00};
				phase_d        = serc_pkg::PH_LEN_LO;
			end
			serc_pkg::PH_LEN_LO: begin
				length_field_d = {length_field_q[15:8], rx.rx_byte};
				byte_index_d   = '0;
				phase_d        = serc_pkg::PH_BODY;
			end
			serc_pkg::PH_BODY: begin
				if (idx_lt || idx_eq) begin
					byte_index_d = byte_index_q + IDX_W'(1);
				end else begin
					phase_d = serc_pkg::PH_CRC_HI;
				end
			end
			serc_pkg::PH_CRC_HI: begin
				phase_d = serc_pkg::PH_CRC_LO;
			end
			serc_pkg::PH_CRC_LO: begin
				phase_d      = serc_pkg::PH_HUNT;
				poll_count_d = '0;
				byte_index_d = '0;
			end
			default: begin
				phase_d = serc_pkg::PH_HUNT;
			end
		endcase
	end

	// token for the back end
	always_comb begin
		tok_valid   = 1'b0;
		tok.kind    = serc_pkg::TK_SYNC;
		tok.rx      = rx.rx_byte;
		tok.key_idx = byte_index_q[3:0];
		tok.len_ok  = len_ok;
		unique case (phase_q)
			serc_pkg::PH_HUNT: begin
				if (is_sync) begin
					tok_valid = 1'b1;
					tok.kind  = serc_pkg::TK_SYNC;
				end else if (timeout) begin
					tok_valid = 1'b1;
					tok.kind  = serc_pkg::TK_TIMEOUT;
				end
			end
			serc_pkg::PH_BODY: begin
				tok_valid = 1'b1;
				if (idx_lt) begin
					tok.kind = serc_pkg::TK_DATA;
				end else if (idx_eq) begin
					tok.kind = serc_pkg::TK_STAT_HI;
				end else begin
					tok.kind = serc_pkg::TK_STAT_LO;
				end
			end
			serc_pkg::PH_CRC_HI: begin
				tok_valid = 1'b1;
				tok.kind  = serc_pkg::TK_CRC_HI;
			end
			serc_pkg::PH_CRC_LO: begin
				tok_valid = 1'b1;
				tok.kind  = serc_pkg::TK_CRC_LO;
			end
			default: begin
				tok_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= serc_pkg::PH_HUNT;
			poll_count_q   <= '0;
			byte_index_q   <= '0;
			length_field_q <= '0;
		end else if (accept) begin
			phase_q        <= phase_d;
			poll_count_q   <= poll_count_d;
			byte_index_q   <= byte_index_d;
			length_field_q <= length_field_d;
		end
	end

endmodule

>>> src/serc_queue.sv
// ----------------------------------------------------------------------------
// serc_queue
// short token queue between parser and checker
// ----------------------------------------------------------------------------
module serc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  serc_pkg::tok_t  push_tok,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output serc_pkg::tok_t  head
);

	localparam int CNT_W = serc_pkg::Q_PTR_W + 1;

	serc_pkg::tok_t               mem_q [serc_pkg::Q_DEPTH];
	logic [serc_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]             count_q;

	assign full      = count_q == CNT_W'(serc_pkg::Q_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_ptr_q];

	function automatic logic [serc_pkg::Q_PTR_W-1:0] ptr_next(
		input logic [serc_pkg::Q_PTR_W-1:0] p);
		return (p == serc_pkg::Q_PTR_W'(serc_pkg::Q_DEPTH - 1)) ? '0
			: p + serc_pkg::Q_PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> src/serc_back.sv
// ----------------------------------------------------------------------------
// serc_back
// checker: crc, descrambling, status capture, verdict and result register
// ----------------------------------------------------------------------------
module serc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  serc_pkg::cfg_t  cfg,
	input  logic            q_not_empty,
	input  serc_pkg::tok_t  head,
	output logic            pop,
	serc_out_if.source      rsp
);

	logic [15:0]    crc_q, crc_d;
	logic [15:0]    status_q, status_d;
	logic [7:0]     crc_hi_q, crc_hi_d;
	serc_pkg::res_t res_q, res_d;
	logic           res_valid_q;
	logic           load;

	logic [7:0]     plain;
	logic [15:0]    got;

	assign pop   = q_not_empty && (!res_valid_q || rsp.ready);
	assign plain = cfg.encrypt_enable ? (head.rx ^ serc_pkg::key_byte(cfg.key, head.key_idx))
		: head.rx;
	assign got   = {crc_hi_q, head.rx};

	always_comb begin
		crc_d    = crc_q;
		status_d = status_q;
		crc_hi_d = crc_hi_q;
		load     = 1'b0;
		res_d    = '{kind: serc_pkg::K_DATA, data_byte: 8'h00, verdict: serc_pkg::V_OK,
			status_hi: 8'h00, status_lo: 8'h00, last: 1'b0};
		unique case (head.kind)
			serc_pkg::TK_SYNC: begin
				crc_d    = serc_pkg::CRC_INIT;
				status_d = '0;
				crc_hi_d = '0;
			end
			serc_pkg::TK_TIMEOUT: begin
				load          = 1'b1;
				res_d.kind    = serc_pkg::K_VERDICT;
				res_d.verdict = serc_pkg::V_TIMEOUT;
				res_d.last    = 1'b1;
			end
			serc_pkg::TK_DATA: begin
				crc_d           = serc_pkg::crc_update(crc_q, head.rx);
				load            = head.len_ok;
				res_d.data_byte = plain;
			end
			serc_pkg::TK_STAT_HI: begin
				crc_d    = serc_pkg::crc_update(crc_q, head.rx);
				status_d = {plain, 8'h00};
			end
			serc_pkg::TK_STAT_LO: begin
				crc_d    = serc_pkg::crc_update(crc_q, head.rx);
				status_d = {status_q[15:8], plain};
			end
			serc_pkg::TK_CRC_HI: begin
				crc_hi_d = head.rx;
			end
			serc_pkg::TK_CRC_LO: begin
				load            = 1'b1;
				res_d.kind      = serc_pkg::K_VERDICT;
				res_d.status_hi = status_q[15:8];
				res_d.status_lo = status_q[7:0];
				res_d.last      = 1'b1;
				if (!head.len_ok) begin
					res_d.verdict = serc_pkg::V_LENGTH;
				end else if (got != crc_q) begin
					res_d.verdict = serc_pkg::V_CRC;
				end else if (status_q != serc_pkg::STATUS_OK) begin
					res_d.verdict = serc_pkg::V_STATUS;
				end else begin
					res_d.verdict = serc_pkg::V_OK;
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= serc_pkg::CRC_INIT;
			status_q    <= '0;
			crc_hi_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				crc_q    <= crc_d;
				status_q <= status_d;
				crc_hi_q <= crc_hi_d;
			end
			if (pop && load) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && load) begin
			res_q <= res_d;
		end
	end

	assign rsp.valid     = res_valid_q;
	assign rsp.kind      = res_q.kind;
	assign rsp.data_byte = res_q.data_byte;
	assign rsp.verdict   = res_q.verdict;
	assign rsp.status_hi = res_q.status_hi;
	assign rsp.status_lo = res_q.status_lo;
	assign rsp.last      = res_q.last;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the secure element response checker: a scoreboard
// tracks the frame parser state word by word, predicts every data word and
// verdict, and compares them with what leaves the rsp channel
// ----------------------------------------------------------------------------
module tb;
	import serc_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 12;
	localparam int CAP_LENGTH    = MAX_FRAME_D - 6;
	// index outside the register map, must be ignored by the block
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

	typedef enum int {
		FRAME_GOOD,
		FRAME_BAD_LENGTH,
		FRAME_BAD_CRC,
		FRAME_BAD_STATUS
	} frame_flaw_t;

	typedef enum int {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES
	} fill_t;

	// ------------------------------------------------------------------------
	// scoreboard: shadow copy of the registers and the parser state
	// ------------------------------------------------------------------------
	class frame_scoreboard;
		logic [11:0] exp_len;
		logic        enc;
		logic [63:0] key_lo;
		logic [63:0] key_hi;
		logic [8:0]  poll_limit;

		phase_t      phase;
		logic [8:0]  polls;
		logic [12:0] pos;
		logic [15:0] crc;
		logic [15:0] len_field;
		logic [15:0] status;
		logic [7:0]  crc_hi;

		res_t expected_words[$];
		int   errors;

		function new();
			exp_len    = '0;
			enc        = 1'b0;
			key_lo     = '0;
			key_hi     = '0;
			poll_limit = POLL_LIMIT_RESET;
			phase      = PH_HUNT;
			polls      = '0;
			pos        = '0;
			crc        = CRC_INIT;
			len_field  = '0;
			status     = '0;
			crc_hi     = '0;
			errors     = 0;
		endfunction

		function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
			logic [15:0] r;
			r = c ^ {b, 8'h00};
			for (int k = 0; k < 8; k++) begin
				r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
			end
			return r;
		endfunction

		function logic [7:0] key_at(logic [12:0] p);
			logic [127:0] k;
			k = {key_hi, key_lo};
			return k[p[3:0]*8 +: 8];
		endfunction

		function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				CFG_EXPECTED_LENGTH: exp_len = v[11:0];
				CFG_ENCRYPT_ENABLE: enc = v[0];
				CFG_KEY_LOW: key_lo = v;
				CFG_KEY_HIGH: key_hi = v;
				CFG_POLL_LIMIT: poll_limit = v[8:0];
				default: ;
			endcase
		endfunction

		// one accepted rx word, pushes the result it causes if any
		function void note_byte(logic [7:0] b);
			int unsigned cap;
			bit          len_ok;
			logic [7:0]  plain;
			res_t        w;
			cap    = (exp_len > CAP_LENGTH) ? CAP_LENGTH : exp_len;
			len_ok = (len_field == cap + 2);
			w      = '0;
			case (phase)
				PH_HUNT: begin
					if (b == SYNC_BYTE) begin
						phase     = PH_LEN_HI;
						polls     = '0;
						pos       = '0;
						crc       = CRC_INIT;
						len_field = '0;
						status    = '0;
						crc_hi    = '0;
					end else begin
						polls = polls + 9'd1;
						// a limit of zero acts like one
						if (polls >= poll_limit || polls == 9'd0) begin
							polls     = '0;
							w.kind    = K_VERDICT;
							w.verdict = V_TIMEOUT;
							w.last    = 1'b1;
							expected_words.push_back(w);
						end
					end
				end
				PH_LEN_HI: begin
					len_field = {b, 8'h00};
					phase     = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_field[7:0] = b;
					phase          = PH_BODY;
					pos            = '0;
				end
				PH_BODY: begin
					crc   = crc_next(crc, b);
					plain = enc ? (b ^ key_at(pos)) : b;
					if (pos < cap) begin
						pos = pos + 13'd1;
						if (len_ok) begin
							w.kind      = K_DATA;
							w.data_byte = plain;
							expected_words.push_back(w);
						end
					end else if (pos == cap) begin
						status = {plain, 8'h00};
						pos    = pos + 13'd1;
					end else begin
						// anything past the first status byte closes the body
						status[7:0] = plain;
						phase       = PH_CRC_HI;
					end
				end
				PH_CRC_HI: begin
					crc_hi = b;
					phase  = PH_CRC_LO;
				end
				default: begin
					if (!len_ok) w.verdict = V_LENGTH;
					else if ({crc_hi, b} != crc) w.verdict = V_CRC;
					else if (status != STATUS_OK) w.verdict = V_STATUS;
					else w.verdict = V_OK;
					w.kind      = K_VERDICT;
					w.status_hi = status[15:8];
					w.status_lo = status[7:0];
					w.last      = 1'b1;
					expected_words.push_back(w);
					phase = PH_HUNT;
					polls = '0;
					pos   = '0;
					crc   = CRC_INIT;
				end
			endcase
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		// one accepted rsp word against the oldest prediction
		function void check_word(res_t got);
			res_t want;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_words.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("data_byte", want.data_byte, got.data_byte);
			compare_field("verdict", want.verdict, got.verdict);
			compare_field("status_hi", want.status_hi, got.status_hi);
			compare_field("status_lo", want.status_lo, got.status_lo);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, reset, channels, block
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	frame_scoreboard model = new();

	// percent of cycles each side sits idle
	int sender_idle_pct = 27;
	int receiver_idle_pct = 80;
	int bytes_sent = 0;
	int cycles = 0;

	serc_in_if  rx_ch();
	serc_out_if rsp_ch();
	serc_cfg_if cfg_ch();

	secure_element_response_checker_top u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d words outstanding", $time,
				model.expected_words.size());
			$display("tb: FAIL");
			$finish;
		end
	end

	// all handshakes are observed at the rising edge, before any update
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				model.apply_reg(cfg_ch.index, cfg_ch.data);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				model.check_word(res_t'({rsp_ch.kind, rsp_ch.data_byte, rsp_ch.verdict,
					rsp_ch.status_hi, rsp_ch.status_lo, rsp_ch.last}));
			end
			if (rx_ch.valid && rx_ch.ready) begin
				model.note_byte(rx_ch.rx_byte);
			end
		end
	end

	// receiver: random backpressure, retimed at every falling edge
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	// ------------------------------------------------------------------------
	// drivers, all entered and left at a falling edge
	// ------------------------------------------------------------------------

	// one rx word; valid stays high on return so back-to-back words don't glitch
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	// cfg write; valid is dropped by the caller after the last one
	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// drain all predicted words, then give the pipeline time to empty of
	// bytes that produce nothing (sync, length, plain polls)
	task automatic settle();
		rx_ch.valid <= 1'b0;
		while (model.expected_words.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic configure(input logic [11:0] len, input logic en,
		input logic [63:0] klo, input logic [63:0] khi, input logic [8:0] polls,
		input int tx_pct, input int rx_pct);
		settle();
		program_reg(CFG_EXPECTED_LENGTH, {52'(0), len});
		program_reg(CFG_ENCRYPT_ENABLE, {63'(0), en});
		program_reg(CFG_KEY_LOW, klo);
		program_reg(CFG_KEY_HIGH, khi);
		program_reg(CFG_POLL_LIMIT, {55'(0), polls});
		program_reg(CFG_UNUSED_IDX, {$urandom, $urandom});
		cfg_ch.valid <= 1'b0;
		sender_idle_pct   = tx_pct;
		receiver_idle_pct = rx_pct;
	endtask

	// bytes seen while hunting; sync may be excluded for long poll runs
	task automatic send_noise(input int n, input bit no_sync);
		logic [7:0] b;
		for (int k = 0; k < n; k++) begin
			b = 8'($urandom_range(0, 255));
			if (no_sync && b == SYNC_BYTE) b = ~b;
			send_byte(b);
		end
	endtask

	// full frame at the current settings; crc covers the raw bytes on the
	// link, the status word check is on the descrambled ones
	task automatic send_frame(input frame_flaw_t flaw, input fill_t fill);
		int unsigned cap;
		logic [15:0] lf;
		logic [15:0] crc;
		logic [15:0] plain_status;
		logic [7:0]  d;
		logic [7:0]  sh;
		logic [7:0]  sl;
		cap = (model.exp_len > CAP_LENGTH) ? CAP_LENGTH : model.exp_len;
		lf  = 16'(cap + 2);
		if (flaw == FRAME_BAD_LENGTH) lf = lf ^ (16'h0001 << $urandom_range(0, 15));
		send_byte(SYNC_BYTE);
		send_byte(lf[15:8]);
		send_byte(lf[7:0]);
		crc = CRC_INIT;
		for (int k = 0; k < cap; k++) begin
			case (fill)
				FILL_ZERO: d = 8'h00;
				FILL_ONES: d = 8'hFF;
				default: d = 8'($urandom_range(0, 255));
			endcase
			crc = model.crc_next(crc, d);
			send_byte(d);
		end
		plain_status = (flaw == FRAME_BAD_STATUS) ? 16'($urandom) : STATUS_OK;
		sh = plain_status[15:8];
		sl = plain_status[7:0];
		if (model.enc) begin
			sh = sh ^ model.key_at(13'(cap));
			sl = sl ^ model.key_at(13'(cap + 1));
		end
		crc = model.crc_next(crc, sh);
		crc = model.crc_next(crc, sl);
		if (flaw == FRAME_BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
		send_byte(sh);
		send_byte(sl);
		send_byte(crc[15:8]);
		send_byte(crc[7:0]);
	endtask

	// random mix of clean frames, damaged frames and stray bytes
	task automatic random_traffic(input int budget);
		int start;
		int r;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			r = $urandom_range(0, 99);
			if (r < 55) send_frame(FRAME_GOOD, FILL_RANDOM);
			else if (r < 65) send_frame(FRAME_BAD_STATUS, FILL_RANDOM);
			else if (r < 75) send_frame(FRAME_BAD_LENGTH, FILL_RANDOM);
			else if (r < 85) send_frame(FRAME_BAD_CRC, FILL_RANDOM);
			else send_noise($urandom_range(1, 12), 1'b0);
		end
	endtask

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = 8'h00;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = '0;
		cfg_ch.data   = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: one data byte per frame, poll limit zero
		configure(12'd1, 1'b0, 64'h0, 64'h0, 9'd0, 27, 80);
		send_byte(8'h00);                        // immediate timeout
		send_byte(8'hFF);                        // and again
		send_frame(FRAME_GOOD, FILL_ONES);       // clean frame, all-ones data
		send_frame(FRAME_BAD_CRC, FILL_ZERO);    // crc error, all-zero data
		// frame left open in the status word, the length shrinks under it
		send_byte(SYNC_BYTE);
		send_byte(8'h00);
		send_byte(8'h03);
		send_byte(8'hAA);
		send_byte(8'h90);

		// sender idles lightly, receiver heavily
		configure(12'd0, 1'b0, 64'h0, 64'h0, 9'd1, 27, 80);
		random_traffic(230);
		configure(12'd5, 1'b1, {$urandom, $urandom}, {$urandom, $urandom}, 9'd3, 27, 80);
		random_traffic(230);
		// oversize length gets capped: a frame with the capped length passes
		// its data words, then a short length closes it early
		configure(12'hFFF, 1'b1, '1, '1, 9'd256, 27, 80);
		send_byte(SYNC_BYTE);
		send_byte(8'((CAP_LENGTH + 2) >> 8));
		send_byte(8'(CAP_LENGTH + 2));
		send_noise(16, 1'b0);
		configure(12'd2, 1'b0, 64'h0, 64'h0, 9'd256, 27, 80);
		send_noise(3, 1'b0);

		// sender idles heavily, receiver lightly
		configure(12'd12, 1'b0, {$urandom, $urandom}, {$urandom, $urandom}, 9'd0, 80, 27);
		random_traffic(230);
		// widest poll limit, reached by one long run without sync
		configure(12'd3, 1'b1, 64'h0, '1, 9'd511, 80, 27);
		send_noise(511, 1'b1);
		random_traffic(100);
		// key index wraps inside the body
		configure(12'd17, 1'b1, {$urandom, $urandom}, {$urandom, $urandom}, 9'd7, 80, 27);
		random_traffic(230);

		// no idling on either side
		configure(12'd1, 1'b0, {$urandom, $urandom}, {$urandom, $urandom}, 9'd256, 0, 0);
		random_traffic(230);
		configure(12'd30, 1'b1, {$urandom, $urandom}, {$urandom, $urandom}, 9'd2, 0, 0);
		random_traffic(150);

		settle();
		if (model.errors == 0 && model.expected_words.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/serc_pkg.sv
src/serc_in_if.sv
src/serc_out_if.sv
src/serc_cfg_if.sv
src/serc_front.sv
src/serc_queue.sv
src/serc_back.sv
src/secure_element_response_checker_top.sv
tb/tb.sv
